FILE: rtl/epvt_pkg.sv
// Shared types and constants for the encoder position and velocity tracker.
`default_nettype none
package epvt_pkg;

  typedef struct packed {
    logic        mode;
    logic [15:0] counter;
    logic [63:0] timestamp_us;
  } in_t;

  typedef struct packed {
    logic signed [40:0] position;
    logic signed [63:0] velocity;
  } out_t;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgOverflowCount = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgResolution    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgReverseDir    = 2'd2;

  localparam logic signed [31:0] ResolutionReset = 32'sd65536;

  localparam int PosW  = 41;
  localparam int SumW  = 49;
  localparam int DposW = 48;
  localparam int MagW  = 47;
  localparam int ProdW = 67;
  localparam int TimeW = 64;

  localparam logic signed [SumW-1:0] PosLimit = 49'sd655360000000;
  localparam logic [19:0] UsPerS = 20'd1000000;

  localparam logic signed [63:0] VelMax = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] VelMin = 64'sh8000_0000_0000_0000;

endpackage
`default_nettype wire

FILE: rtl/epvt_div.sv
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none
module epvt_div #(
  parameter int NumW = epvt_pkg::ProdW,
  parameter int DenW = epvt_pkg::TimeW
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 done_o,
  output logic [NumW-1:0]      quot_o
);

  localparam int CntW = $clog2(NumW + 1);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW-1:0] rem_q;
  logic [NumW-1:0] quo_q;

  logic [DenW:0]   trial;
  logic [DenW+1:0] diff;
  logic            ge;

  assign trial = {rem_q, quo_q[NumW-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_i};
  assign ge    = ~diff[DenW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
        rem_q  <= '0;
        quo_q  <= num_i;
      end else if (busy_q) begin
        rem_q <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
        quo_q <= {quo_q[NumW-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

FILE: rtl/encoder_position_velocity_tracker.sv
// Top level: sequencer and datapath of the encoder position and velocity tracker.
// A sample with a velocity update passes the delta, wrap, multiply, position, low and high
// product, 67-step serial divider and saturation steps; one without skips the velocity steps,
// the first sample goes straight to output, and a clear gives no result. Ready only while
// the sequencer is idle; a waiting result holds it in its last step.
// Reset: position, velocity, stored counter and time are zeroed; registers take reset values.
`default_nettype none
module encoder_position_velocity_tracker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [epvt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [epvt_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire epvt_pkg::in_t                 in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output epvt_pkg::out_t                     out_data_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DELTA = 4'd1;
  localparam logic [3:0] S_WRAP  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_POS   = 4'd4;
  localparam logic [3:0] S_MLO   = 4'd5;
  localparam logic [3:0] S_MHI   = 4'd6;
  localparam logic [3:0] S_DSTRT = 4'd7;
  localparam logic [3:0] S_DWAIT = 4'd8;
  localparam logic [3:0] S_SAT   = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0] state_q, state_d;

  logic [15:0]        oc_q;
  logic signed [31:0] res_q;
  logic               rev_q;

  logic [15:0]                       prev_cnt_q;
  logic [epvt_pkg::TimeW-1:0]        prev_time_q;
  logic signed [epvt_pkg::PosW-1:0]  pos_q;
  logic signed [63:0]                vel_q;

  epvt_pkg::in_t                     item_q;
  logic [16:0]                       draw_q;
  logic signed [17:0]                delta_q;
  logic signed [epvt_pkg::DposW-1:0] dpos_q;
  logic [epvt_pkg::MagW-1:0]         mag_q;
  logic                              neg_q;
  logic [epvt_pkg::TimeW-1:0]        dt_q;
  logic                              tgt_q;
  logic [epvt_pkg::ProdW-1:0]        prod_q;

  logic           out_valid_q;
  epvt_pkg::out_t out_q;

  logic in_xfer, out_xfer;
  logic div_start, div_done;
  logic [epvt_pkg::ProdW-1:0] quot;

  logic signed [17:0] dr, half_s, ocs, dw, dn;
  logic signed [49:0] mul_full;
  logic signed [epvt_pkg::SumW-1:0] pos_sum;
  logic signed [epvt_pkg::DposW-1:0] dpos_abs;
  logic [43:0] plo;
  logic [42:0] phi;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i & in_ready_o;
  assign out_xfer   = out_valid_q & out_ready_i;
  assign div_start  = (state_q == S_DSTRT);

  always_comb begin
    dr     = {draw_q[16], draw_q};
    half_s = {3'b000, oc_q[15:1]};
    ocs    = {2'b00, oc_q};
    dw     = dr;
    if (oc_q != 16'd0) begin
      if (dr > half_s) begin
        dw = dr - ocs;
      end else if (dr < -half_s) begin
        dw = dr + ocs;
      end
    end
    dn = rev_q ? -dw : dw;
  end

  assign mul_full = delta_q * res_q;
  assign pos_sum  = {{(epvt_pkg::SumW-epvt_pkg::PosW){pos_q[epvt_pkg::PosW-1]}}, pos_q}
                  + {dpos_q[epvt_pkg::DposW-1], dpos_q};
  assign dpos_abs = dpos_q[epvt_pkg::DposW-1] ? -dpos_q : dpos_q;
  assign plo      = mag_q[23:0] * epvt_pkg::UsPerS;
  assign phi      = mag_q[46:24] * epvt_pkg::UsPerS;

  epvt_div #(
    .NumW(epvt_pkg::ProdW),
    .DenW(epvt_pkg::TimeW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (prod_q),
    .den_i  (dt_q),
    .done_o (div_done),
    .quot_o (quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_data_i.mode) begin
            state_d = S_IDLE;
          end else if (prev_time_q == '0) begin
            state_d = S_EMIT;
          end else begin
            state_d = S_DELTA;
          end
        end
      end
      S_DELTA: state_d = S_WRAP;
      S_WRAP:  state_d = S_MUL;
      S_MUL:   state_d = S_POS;
      S_POS:   state_d = tgt_q ? S_MLO : S_EMIT;
      S_MLO:   state_d = S_MHI;
      S_MHI:   state_d = S_DSTRT;
      S_DSTRT: state_d = S_DWAIT;
      S_DWAIT: state_d = div_done ? S_SAT : S_DWAIT;
      S_SAT:   state_d = S_EMIT;
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      oc_q        <= '0;
      res_q       <= epvt_pkg::ResolutionReset;
      rev_q       <= 1'b0;
      prev_cnt_q  <= '0;
      prev_time_q <= '0;
      pos_q       <= '0;
      vel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          epvt_pkg::CfgOverflowCount: oc_q  <= cfg_data_i[15:0];
          epvt_pkg::CfgResolution:    res_q <= cfg_data_i;
          epvt_pkg::CfgReverseDir:    rev_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        if (in_data_i.mode) begin
          pos_q <= '0;
          vel_q <= '0;
        end else if (prev_time_q == '0) begin
          prev_cnt_q  <= in_data_i.counter;
          prev_time_q <= in_data_i.timestamp_us;
        end
      end
      if (state_q == S_DELTA) begin
        prev_cnt_q  <= item_q.counter;
        prev_time_q <= item_q.timestamp_us;
      end
      if (state_q == S_POS) begin
        if (pos_sum > epvt_pkg::PosLimit || pos_sum < -epvt_pkg::PosLimit) begin
          pos_q <= '0;
        end else begin
          pos_q <= pos_sum[epvt_pkg::PosW-1:0];
        end
      end
      if (state_q == S_SAT) begin
        if (!neg_q) begin
          vel_q <= (quot[epvt_pkg::ProdW-1:63] != '0) ? epvt_pkg::VelMax
                                                      : {1'b0, quot[62:0]};
        end else begin
          vel_q <= (quot[epvt_pkg::ProdW-1:63] != '0) ? epvt_pkg::VelMin
                                                      : -$signed({1'b0, quot[62:0]});
        end
      end
      if (state_q == S_EMIT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= in_data_i;
    end
    case (state_q)
      S_DELTA: begin
        draw_q <= {1'b0, item_q.counter} - {1'b0, prev_cnt_q};
        dt_q   <= item_q.timestamp_us - prev_time_q;
        tgt_q  <= item_q.timestamp_us > prev_time_q;
      end
      S_WRAP: delta_q <= dn;
      S_MUL:  dpos_q  <= mul_full[epvt_pkg::DposW-1:0];
      S_POS: begin
        mag_q <= dpos_abs[epvt_pkg::MagW-1:0];
        neg_q <= dpos_q[epvt_pkg::DposW-1];
      end
      S_MLO: prod_q <= {23'd0, plo};
      S_MHI: prod_q <= prod_q + {phi, 24'd0};
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_q.position <= pos_q;
          out_q.velocity <= vel_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
